// ===== design/mdtp_pkg.sv =====
// ----------------------------------------------------------------------------
// mdtp_pkg
// Shared types and constants for the MD tag mismatch parser: item structs,
// the ASCII codes the parser recognizes and the reference base codes.
// ----------------------------------------------------------------------------
package mdtp_pkg;

  localparam int INDEX_WIDTH = 16;
  localparam int CHAR_WIDTH  = 8;
  localparam int BASE_WIDTH  = 3;

  localparam logic [INDEX_WIDTH-1:0] IDX_MAX = {INDEX_WIDTH{1'b1}};

  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CHAR_CARET = 8'h5E;
  localparam logic [CHAR_WIDTH-1:0] CHAR_A     = 8'h41;
  localparam logic [CHAR_WIDTH-1:0] CHAR_C     = 8'h43;
  localparam logic [CHAR_WIDTH-1:0] CHAR_G     = 8'h47;
  localparam logic [CHAR_WIDTH-1:0] CHAR_T     = 8'h54;
  localparam logic [CHAR_WIDTH-1:0] CHAR_N     = 8'h4E;

  localparam logic [BASE_WIDTH-1:0] BASE_A = 3'd0;
  localparam logic [BASE_WIDTH-1:0] BASE_C = 3'd1;
  localparam logic [BASE_WIDTH-1:0] BASE_G = 3'd2;
  localparam logic [BASE_WIDTH-1:0] BASE_T = 3'd3;
  localparam logic [BASE_WIDTH-1:0] BASE_N = 3'd4;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] md_char;
    logic                  record_start;
  } md_in_t;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] match_index;
    logic [BASE_WIDTH-1:0]  ref_base;
    logic                   bad_char;
  } md_out_t;

  // Result of one parsing step, handed from the core to the output stage.
  typedef struct packed {
    logic    valid;
    md_out_t item;
  } mdtp_res_t;

endpackage

// ===== design/mdtp_core.sv =====
// ----------------------------------------------------------------------------
// mdtp_core
// Parser state (run count, matched-base index, deletion flag) and the
// single-pass next-state and result logic for one character.
// ----------------------------------------------------------------------------
module mdtp_core
  import mdtp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  md_in_t    item,
  output mdtp_res_t res
);

  localparam int PROD_WIDTH = INDEX_WIDTH + 4;

  logic [INDEX_WIDTH-1:0] pending_count, pending_count_next;
  logic [INDEX_WIDTH-1:0] base_index, base_index_next;
  logic                   in_deletion, in_deletion_next;

  logic [INDEX_WIDTH-1:0] pc, bi;
  logic                   del;
  logic [PROD_WIDTH-1:0]  run_sum;
  logic [INDEX_WIDTH:0]   fold_sum;
  logic [INDEX_WIDTH-1:0] folded;
  logic [INDEX_WIDTH-1:0] folded_inc;
  logic [INDEX_WIDTH-1:0] digit_run;
  logic                   is_digit, is_caret, is_base;
  logic [BASE_WIDTH-1:0]  base_code;

  // A record start clears the state before the character is handled.
  assign pc  = item.record_start ? '0 : pending_count;
  assign bi  = item.record_start ? '0 : base_index;
  assign del = item.record_start ? 1'b0 : in_deletion;

  assign run_sum = PROD_WIDTH'(pc) * PROD_WIDTH'(10)
                 + PROD_WIDTH'(item.md_char[3:0]);
  assign digit_run = (run_sum > PROD_WIDTH'(IDX_MAX)) ? IDX_MAX
                                                       : run_sum[INDEX_WIDTH-1:0];

  assign fold_sum   = {1'b0, bi} + {1'b0, pc};
  assign folded     = fold_sum[INDEX_WIDTH] ? IDX_MAX : fold_sum[INDEX_WIDTH-1:0];
  assign folded_inc = (folded == IDX_MAX) ? IDX_MAX : folded + INDEX_WIDTH'(1);

  always_comb begin
    is_digit  = item.md_char inside {[CHAR_ZERO:CHAR_NINE]};
    is_caret  = (item.md_char == CHAR_CARET);
    is_base   = 1'b1;
    base_code = BASE_A;
    case (item.md_char)
      CHAR_A:  base_code = BASE_A;
      CHAR_C:  base_code = BASE_C;
      CHAR_G:  base_code = BASE_G;
      CHAR_T:  base_code = BASE_T;
      CHAR_N:  base_code = BASE_N;
      default: is_base = 1'b0;
    endcase
  end

  always_comb begin
    pending_count_next = pc;
    base_index_next    = bi;
    in_deletion_next   = del;
    res.valid            = 1'b0;
    res.item.match_index = bi;
    res.item.ref_base    = BASE_A;
    res.item.bad_char    = 1'b0;
    if (is_digit) begin
      pending_count_next = digit_run;
      in_deletion_next   = 1'b0;
    end else if (is_caret) begin
      pending_count_next = '0;
      base_index_next    = folded;
      in_deletion_next   = 1'b1;
    end else if (is_base) begin
      pending_count_next = '0;
      if (del) begin
        base_index_next = folded;
      end else begin
        base_index_next      = folded_inc;
        res.valid            = 1'b1;
        res.item.match_index = folded;
        res.item.ref_base    = base_code;
      end
    end else begin
      // Unknown characters report the current index and leave state alone.
      res.valid         = 1'b1;
      res.item.bad_char = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= '0;
      base_index    <= '0;
      in_deletion   <= 1'b0;
    end else if (step) begin
      pending_count <= pending_count_next;
      base_index    <= base_index_next;
      in_deletion   <= in_deletion_next;
    end
  end

`ifndef SYNTHESIS
  a_mismatch_advances: assert property (@(posedge clk) disable iff (rst)
    (step && res.valid && !res.item.bad_char) |=>
      (base_index == IDX_MAX ||
       base_index == $past(res.item.match_index) + INDEX_WIDTH'(1)))
    else $error("index did not advance after a mismatch");

  a_bad_keeps_base: assert property (@(posedge clk) disable iff (rst)
    (step && res.valid && res.item.bad_char) |=> base_index == $past(bi))
    else $error("bad character changed the base index");

  a_digit_leaves_deletion: assert property (@(posedge clk) disable iff (rst)
    (step && is_digit) |=> !in_deletion)
    else $error("digit did not leave deletion");
`endif

endmodule

// ===== design/mdtp_out_stage.sv =====
// ----------------------------------------------------------------------------
// mdtp_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module mdtp_out_stage
  import mdtp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  mdtp_res_t res,
  input  logic      hit_stall,
  output logic      hit_valid,
  output md_out_t   hit_item
);

  logic load;

  assign load = step && res.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else if (load) begin
      hit_valid <= 1'b1;
    end else if (!hit_stall) begin
      hit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hit_item <= res.item;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !(hit_valid && hit_stall))
    else $error("result register overwritten while stalled");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> hit_valid)
    else $error("loaded result not presented");

  a_idle_drains: assert property (@(posedge clk) disable iff (rst)
    (!load && hit_valid && !hit_stall) |=> !hit_valid)
    else $error("taken result presented twice");
`endif

endmodule

// ===== design/md_tag_mismatch_parser_unit.sv =====
// ----------------------------------------------------------------------------
// md_tag_mismatch_parser_unit
// Parses an MD tag one character per item and reports mismatch positions.
// ----------------------------------------------------------------------------
// The char channel (char_valid, char_stall, char_item) carries one ASCII
// character of the MD tag per item; record_start marks the first character
// of a new tag and clears the parser state before it is handled.
// The hit channel (hit_valid, hit_stall, hit_item) carries zero or one
// result per character: a mismatch position with its reference base, or a
// bad-character report.
// A character is taken into the input register and parsed from there once
// the result register can advance; its result is then loaded into the result
// register, which presents it on the hit channel.
// One character is taken every cycle while the hit channel does not stall; the
// loop that updates run count and index sets that figure.
// When the receiver stalls, the result register holds and the input
// register fills; after that char_stall rises until the result is taken.
// Synchronous reset empties both registers and clears the parser state.
// ----------------------------------------------------------------------------
module md_tag_mismatch_parser_unit
  import mdtp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    char_valid,
  output logic    char_stall,
  input  md_in_t  char_item,
  output logic    hit_valid,
  input  logic    hit_stall,
  output md_out_t hit_item
);

  logic      s1_valid;
  md_in_t    s1_item;
  logic      advance;
  logic      step;
  logic      accept;
  mdtp_res_t res;

  assign advance    = !(hit_valid && hit_stall);
  assign step       = s1_valid && advance;
  assign char_stall = s1_valid && !advance;
  assign accept     = char_valid && !char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= char_item;
    end
  end

  mdtp_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (s1_item),
    .res  (res)
  );

  mdtp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .res       (res),
    .hit_stall (hit_stall),
    .hit_valid (hit_valid),
    .hit_item  (hit_item)
  );

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> (s1_valid && hit_valid && hit_stall))
    else $error("input stalled with room to spare");

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_item)))
    else $error("waiting item lost");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted item not registered");
`endif

endmodule

// ===== tb/tb_md_tag_mismatch_parser_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_md_tag_mismatch_parser_unit
// Self-checking bench for the MD tag mismatch parser. A directed tag covers
// saturation, deletions, bad characters and record starts. Random MD tags
// with some noise follow in three phases of sender and receiver idling. Every
// accepted character goes through a local parser model, and each result from
// the block is checked field by field against the oldest predicted hit.
// ----------------------------------------------------------------------------
module tb_md_tag_mismatch_parser_unit;
  import mdtp_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 7;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 640;
  localparam int MAX_REPORTS  = 10;

  logic    clk        = 1'b0;
  logic    rst        = 1'b1;
  logic    char_valid = 1'b0;
  logic    char_stall;
  md_in_t  char_item  = '0;
  logic    hit_valid;
  logic    hit_stall  = 1'b0;
  md_out_t hit_item;

  md_tag_mismatch_parser_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item),
    .hit_valid  (hit_valid),
    .hit_stall  (hit_stall),
    .hit_item   (hit_item)
  );

  always #CLK_HALF clk = ~clk;

  // Characters waiting to be offered, and hits the model says must come out.
  md_in_t  md_chars_q[$];
  md_out_t hits_due_q[$];
  md_out_t due_hit;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req_cnt  = 0;
  int unsigned hold_ack_cnt  = 0;
  int unsigned hold_left     = 0;
  logic        char_fire     = 1'b0;

  int unsigned queued     = 0;
  int unsigned chars_done = 0;
  int unsigned hits_seen  = 0;
  int unsigned miss_hits  = 0;
  int unsigned bad_hits   = 0;
  int unsigned del_skips  = 0;
  int unsigned errors     = 0;
  int unsigned cycles     = 0;

  // Parser model state.
  logic [INDEX_WIDTH-1:0] run_count = '0;
  logic [INDEX_WIDTH-1:0] match_pos = '0;
  logic                   del_mode  = 1'b0;

  function automatic logic [INDEX_WIDTH-1:0] sat_sum(input logic [INDEX_WIDTH-1:0] a,
                                                     input logic [INDEX_WIDTH-1:0] b);
    logic [INDEX_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[INDEX_WIDTH] ? IDX_MAX : s[INDEX_WIDTH-1:0];
  endfunction

  task automatic parse_md_char(input md_in_t c);
    logic [INDEX_WIDTH+4:0] grown;
    logic [BASE_WIDTH-1:0]  code;
    logic                   is_base;
    md_out_t                hit;
    if (c.record_start) begin
      run_count = '0;
      match_pos = '0;
      del_mode  = 1'b0;
    end
    is_base = 1'b1;
    case (c.md_char)
      CHAR_A: code = BASE_A;
      CHAR_C: code = BASE_C;
      CHAR_G: code = BASE_G;
      CHAR_T: code = BASE_T;
      CHAR_N: code = BASE_N;
      default: begin
        code    = BASE_A;
        is_base = 1'b0;
      end
    endcase
    if (c.md_char >= CHAR_ZERO && c.md_char <= CHAR_NINE) begin
      grown     = (INDEX_WIDTH+5)'(run_count) * (INDEX_WIDTH+5)'(10)
                + (INDEX_WIDTH+5)'(c.md_char - CHAR_ZERO);
      run_count = (grown > IDX_MAX) ? IDX_MAX : grown[INDEX_WIDTH-1:0];
      del_mode  = 1'b0;
    end else if (c.md_char == CHAR_CARET) begin
      match_pos = sat_sum(match_pos, run_count);
      run_count = '0;
      del_mode  = 1'b1;
    end else if (!is_base) begin
      // A bad character reports the current index and leaves the state alone.
      hit.match_index = match_pos;
      hit.ref_base    = BASE_A;
      hit.bad_char    = 1'b1;
      hits_due_q      = {hits_due_q, hit};
      bad_hits++;
    end else begin
      match_pos = sat_sum(match_pos, run_count);
      run_count = '0;
      if (del_mode) begin
        del_skips++;
      end else begin
        hit.match_index = match_pos;
        hit.ref_base    = code;
        hit.bad_char    = 1'b0;
        hits_due_q      = {hits_due_q, hit};
        match_pos = sat_sum(match_pos, INDEX_WIDTH'(1));
        miss_hits++;
      end
    end
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: hit %0d field %s differs: expected %0d, got %0d",
                 $realtime, hits_seen, what, want, got);
    end
  endtask

  // Driver: a new item goes out only once the previous one was taken.
  always @(negedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (!char_valid || char_fire) begin
      if (md_chars_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        char_item  <= md_chars_q.pop_front();
        char_valid <= 1'b1;
      end else begin
        char_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold when requested.
  always @(negedge clk) begin
    if (hold_ack_cnt != hold_req_cnt) begin
      hold_ack_cnt = hold_req_cnt;
      hold_left    = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      hit_stall <= 1'b1;
    end else begin
      hit_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: check outgoing hits first, then run the model on the accepted item.
  always @(posedge clk) begin
    char_fire <= char_valid && !char_stall && !rst;
    if (!rst) begin
      if (hit_valid && !hit_stall) begin
        hits_seen++;
        if (hits_due_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected hit: index %0d, base %0d, bad %0d", $realtime,
                     hit_item.match_index, hit_item.ref_base, hit_item.bad_char);
        end else begin
          due_hit = hits_due_q.pop_front();
          check_field("match_index", 32'(due_hit.match_index), 32'(hit_item.match_index));
          check_field("ref_base", 32'(due_hit.ref_base), 32'(hit_item.ref_base));
          check_field("bad_char", 32'(due_hit.bad_char), 32'(hit_item.bad_char));
        end
      end
      if (char_valid && !char_stall) begin
        parse_md_char(char_item);
        chars_done++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d hits outstanding.",
               cycles, hits_due_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_char(input logic [CHAR_WIDTH-1:0] ch, input logic start);
    md_in_t c;
    c.md_char      = ch;
    c.record_start = start;
    md_chars_q     = {md_chars_q, c};
    queued++;
  endtask

  function automatic logic [CHAR_WIDTH-1:0] rand_base_char();
    case ($urandom_range(4))
      0:       return CHAR_A;
      1:       return CHAR_C;
      2:       return CHAR_G;
      3:       return CHAR_T;
      default: return CHAR_N;
    endcase
  endfunction

  // Mostly short runs; a few long ones push the count and index to saturation.
  task automatic push_number(input logic start);
    int unsigned n;
    int unsigned pick;
    string       digits;
    pick = $urandom_range(99);
    if (pick < 80)
      n = $urandom_range(30);
    else if (pick < 95)
      n = $urandom_range(999);
    else
      n = $urandom_range(99999);
    digits = $sformatf("%0d", n);
    if ($urandom_range(9) == 0)
      digits = {"0", digits};
    for (int i = 0; i < digits.len(); i++)
      push_char(digits[i], start && i == 0);
  endtask

  // One MD tag: a number, then mismatches or deletions each followed by a
  // number. Some tags carry noise bytes, skip a number or lack a record start.
  task automatic push_tag();
    int unsigned elems;
    logic        head;
    head  = ($urandom_range(15) != 0);
    push_number(head);
    elems = $urandom_range(1, 8);
    repeat (elems) begin
      if ($urandom_range(9) == 0) begin
        push_char(CHAR_WIDTH'($urandom_range(255)), $urandom_range(15) == 0);
      end else if ($urandom_range(3) == 0) begin
        push_char(CHAR_CARET, 1'b0);
        repeat ($urandom_range(1, 4)) push_char(rand_base_char(), 1'b0);
      end else begin
        push_char(rand_base_char(), 1'b0);
      end
      if ($urandom_range(7) != 0)
        push_number(1'b0);
    end
  endtask

  task automatic fill_random(input int unsigned count);
    int unsigned stop;
    stop = queued + count;
    while (queued < stop) push_tag();
  endtask

  task automatic wait_drained();
    while (md_chars_q.size() != 0 || char_valid || hits_due_q.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Run count saturates, then the index stays at its maximum after a hit.
    push_char(CHAR_ZERO, 1'b1);
    repeat (5) push_char(CHAR_NINE, 1'b0);
    push_char(CHAR_A, 1'b0);
    push_char(CHAR_C, 1'b0);
    // New tag: a hit, a deletion with skipped letters, a digit that ends it.
    push_char(CHAR_ZERO + CHAR_WIDTH'(1), 1'b1);
    push_char(CHAR_ZERO + CHAR_WIDTH'(2), 1'b0);
    push_char(CHAR_G, 1'b0);
    push_char(CHAR_CARET, 1'b0);
    push_char(CHAR_T, 1'b0);
    push_char(CHAR_N, 1'b0);
    push_char(CHAR_ZERO, 1'b0);
    push_char(CHAR_T, 1'b0);
    // Bad characters: a lowercase letter and both byte extremes.
    push_char(8'h61, 1'b0);
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b0);
    // Record start on a caret and on a bad character.
    push_char(CHAR_CARET, 1'b1);
    push_char(8'h78, 1'b1);
    push_char(CHAR_N, 1'b0);
    push_char(CHAR_ZERO + CHAR_WIDTH'(5), 1'b0);
    push_char(CHAR_CARET, 1'b0);
    push_char(CHAR_A, 1'b0);
    wait_drained();

    send_idle_pct = 19;
    recv_idle_pct = 87;
    fill_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 87;
    recv_idle_pct = 19;
    fill_random(PHASE_ITEMS);
    wait_drained();

    // Full rate; the receiver holds off at first so the block backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req_cnt++;
    fill_random(PHASE_ITEMS);
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Parsed %0d characters in %0d cycles; %0d hits checked: %0d mismatches,",
             chars_done, cycles, hits_seen, miss_hits);
    $display("%0d bad characters, %0d deletion letters skipped, %0d errors.",
             bad_hits, del_skips, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mdtp_pkg.sv
design/mdtp_core.sv
design/mdtp_out_stage.sv
design/md_tag_mismatch_parser_unit.sv
tb/tb_md_tag_mismatch_parser_unit.sv
